// ===== hw/rtl/pptach_pkg.sv =====
`default_nettype none

package pptach_pkg;

    // Width of the tick counter.
    localparam int CNT_W = 16;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_PIN  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ROSE = 2'd1;
    localparam logic [1:0] PH_FELL = 2'd2;

    localparam logic       CFG_WRAP    = 1'b0;
    localparam logic       CFG_TIMEOUT = 1'b1;

    localparam logic [15:0] WRAP_RESET    = 16'd10000;
    localparam logic [31:0] TIMEOUT_RESET = 32'd30;
    localparam logic [15:0] RPM_MAX       = 16'hFFFF;

    // 60 * 65535 fits in 22 bits; the divider retires one quotient bit a step.
    localparam int         DIVD_W    = 22;
    localparam logic [4:0] DIV_STEPS = 5'd22;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [1:0] op;
        logic       pin_level;
    } t_in;

    typedef struct packed {
        logic [15:0] rpm;
        logic [31:0] period_ticks;
        logic [15:0] high_ticks;
        logic [31:0] pulse_total;
        logic        stalled;
    } t_out;

    // Snapshot of one read, handed from the front to the back.
    typedef struct packed {
        logic [15:0] wrap;
        logic [31:0] period;
        logic [15:0] high;
        logic [31:0] pulses;
        logic        stalled;
    } t_job;

    // Queue status seen by the back.
    typedef struct packed {
        logic not_empty;
        t_job head;
    } t_q_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/pptach_queue.sv =====
`default_nettype none

module pptach_queue
    import pptach_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_job    i_job,
    output logic         o_full,
    input  wire logic    i_pop,
    output t_q_stat      o_stat
);

    t_job       r_mem [QDEPTH];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       do_push, do_pop;

    assign o_full           = (r_count == 2'(QDEPTH));
    assign o_stat.not_empty = (r_count != 2'd0);
    assign o_stat.head      = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_stat.not_empty;

    always_comb begin
        n_wr_ptr = do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pptach_front.sv =====
`default_nettype none

module pptach_front
    import pptach_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire t_in         i_in,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_push,
    output t_job             o_job
);

    logic [15:0]      r_wrap, n_wrap;
    logic [31:0]      r_timeout, n_timeout;
    logic             r_prev, n_prev;
    logic [1:0]       r_phase, n_phase;
    logic [CNT_W-1:0] r_tick, n_tick;
    logic [31:0]      r_ovf, n_ovf;
    logic [15:0]      r_high, n_high;
    logic [31:0]      r_period, n_period;
    logic [31:0]      r_pulses, n_pulses;

    logic [15:0] wrap_eff;
    logic [32:0] tick_inc;
    logic        wrap_hit;
    logic [32:0] ovf_add;
    logic [31:0] ovf_sat;
    logic [32:0] per_add;
    logic [31:0] per_sat;
    logic        rise, fall;

    always_comb begin
        wrap_eff = (r_wrap == 16'd0) ? 16'd1 : r_wrap;
        tick_inc = 33'(r_tick) + 33'd1;
        wrap_hit = (tick_inc >= 33'(wrap_eff)) || (r_tick == '1);
        ovf_add  = {1'b0, r_ovf} + 33'(r_wrap);
        ovf_sat  = ovf_add[32] ? 32'hFFFF_FFFF : ovf_add[31:0];
        per_add  = 33'(r_tick) + {1'b0, r_ovf};
        per_sat  = per_add[32] ? 32'hFFFF_FFFF : per_add[31:0];
        rise     = !r_prev && i_in.pin_level;
        fall     = r_prev && !i_in.pin_level;
    end

    always_comb begin
        n_wrap    = r_wrap;
        n_timeout = r_timeout;
        n_prev    = r_prev;
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_ovf     = r_ovf;
        n_high    = r_high;
        n_period  = r_period;
        n_pulses  = r_pulses;
        o_push    = 1'b0;

        if (i_cfg_we) begin
            if (i_cfg_idx == CFG_WRAP) begin
                n_wrap = i_cfg_data[15:0];
            end else begin
                n_timeout = i_cfg_data;
            end
        end

        if (i_accept) begin
            case (i_in.op)
                OP_TICK: begin
                    if (wrap_hit) begin
                        n_tick = '0;
                        n_ovf  = ovf_sat;
                    end else begin
                        n_tick = tick_inc[CNT_W-1:0];
                    end
                end
                OP_PIN: begin
                    case (r_phase)
                        PH_IDLE: begin
                            if (rise) begin
                                n_phase = PH_ROSE;
                                n_tick  = '0;
                                n_ovf   = '0;
                            end
                        end
                        PH_ROSE: begin
                            if (fall) begin
                                n_phase = PH_FELL;
                                n_high  = 16'(r_tick);
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end
                        PH_FELL: begin
                            if (rise) begin
                                n_phase  = PH_ROSE;
                                n_period = per_sat;
                                n_tick   = '0;
                                n_ovf    = '0;
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                    n_prev   = i_in.pin_level;
                    n_pulses = r_pulses + 32'd1;
                end
                OP_READ: begin
                    o_push = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_job.wrap    = r_wrap;
        o_job.period  = r_period;
        o_job.high    = r_high;
        o_job.pulses  = r_pulses;
        o_job.stalled = (r_ovf > r_timeout);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap    <= WRAP_RESET;
            r_timeout <= TIMEOUT_RESET;
            r_prev    <= 1'b1;
            r_phase   <= PH_IDLE;
            r_tick    <= '0;
            r_ovf     <= '0;
            r_high    <= '0;
            r_period  <= '0;
            r_pulses  <= '0;
        end else begin
            r_wrap    <= n_wrap;
            r_timeout <= n_timeout;
            r_prev    <= n_prev;
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_ovf     <= n_ovf;
            r_high    <= n_high;
            r_period  <= n_period;
            r_pulses  <= n_pulses;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pptach_back.sv =====
`default_nettype none

module pptach_back
    import pptach_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_q_stat i_stat,
    output logic         o_take,
    output logic         o_valid,
    output t_out         o_out,
    input  wire logic    i_pop
);

    logic              r_busy, n_busy;
    logic [4:0]        r_step, n_step;
    logic              r_valid, n_valid;
    logic [DIVD_W-1:0] r_dvd, n_dvd;
    logic [31:0]       r_dvs, n_dvs;
    logic [31:0]       r_rem, n_rem;
    logic [DIVD_W-1:0] r_quo, n_quo;
    t_out              r_out, n_out;

    logic [DIVD_W-1:0] scaled;
    logic [32:0]       shifted;
    logic              ge;
    logic [32:0]       diff;
    logic [DIVD_W-1:0] quo_next;

    always_comb begin
        // 60 * wrap as (wrap << 6) - (wrap << 2).
        scaled   = (DIVD_W'(i_stat.head.wrap) << 6) - (DIVD_W'(i_stat.head.wrap) << 2);
        shifted  = {1'b0, r_rem[30:0], r_dvd[DIVD_W-1]} | {r_rem[31], 32'd0};
        ge       = (shifted >= {1'b0, r_dvs});
        diff     = shifted - {1'b0, r_dvs};
        quo_next = {r_quo[DIVD_W-2:0], ge};
    end

    assign o_take  = !r_busy && !r_valid && i_stat.not_empty;
    assign o_valid = r_valid;
    assign o_out   = r_out;

    always_comb begin
        n_busy  = r_busy;
        n_step  = r_step;
        n_valid = r_valid;
        n_dvd   = r_dvd;
        n_dvs   = r_dvs;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_out   = r_out;

        if (r_valid && i_pop) begin
            n_valid = 1'b0;
        end

        if (o_take) begin
            n_out.period_ticks = i_stat.head.period;
            n_out.high_ticks   = i_stat.head.high;
            n_out.pulse_total  = i_stat.head.pulses;
            n_out.stalled      = i_stat.head.stalled;
            n_out.rpm          = 16'd0;
            if (i_stat.head.period == 32'd0 || i_stat.head.stalled) begin
                n_valid = 1'b1;
            end else begin
                n_busy = 1'b1;
                n_step = DIV_STEPS - 5'd1;
                n_dvd  = scaled;
                n_dvs  = i_stat.head.period;
                n_rem  = '0;
                n_quo  = '0;
            end
        end else if (r_busy) begin
            n_rem = ge ? diff[31:0] : shifted[31:0];
            n_dvd = {r_dvd[DIVD_W-2:0], 1'b0};
            n_quo = quo_next;
            if (r_step == 5'd0) begin
                n_busy    = 1'b0;
                n_valid   = 1'b1;
                n_out.rpm = (quo_next > DIVD_W'(RPM_MAX)) ? RPM_MAX : quo_next[15:0];
            end else begin
                n_step = r_step - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            r_busy  <= n_busy;
            r_valid <= n_valid;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_out <= n_out;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pwm_period_capture_tachometer_unit.sv =====
// PWM period-capture tachometer. Items enter through a queue-style port
// (push/full) and carry an op: a timer tick, a pin event with the sampled
// pin level, or a read. Ticks and pin events are taken one per cycle while
// the queue has room and update the counter, the capture state machine and
// the pulse count at once; they produce no result. A read snapshots the
// current measurements and produces one result beat (empty/pop) holding
// the RPM, the captured period and high time, the pulse total and the
// stall flag. The RPM needs floor(60 * wrap_period / period), which a
// bit-serial divider in the back end works out one quotient bit per cycle.
// A read whose period is zero or that finds the unit stalled skips the
// divider. The back end starts the next read in the cycle after the
// previous result is popped. Up to two reads wait in a queue between front
// and back; full rises only when both slots hold reads, so ticks and pin
// events keep flowing while the divider works. Configuration registers
// (0: wrap_period, 1: timeout_limit) are written through i_cfg_we,
// i_cfg_idx and i_cfg_data; the user must write them only while the unit
// is idle, which the unit itself does not enforce.
`default_nettype none

module pwm_period_capture_tachometer_unit
    import pptach_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire t_in         i_in,
    output logic             empty,
    input  wire logic        pop,
    output t_out             o_out,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    logic    q_full;
    logic    q_push;
    t_job    q_job;
    logic    q_take;
    t_q_stat q_stat;
    logic    res_valid;

    // The front accepts every beat while the queue has room; only reads
    // occupy a queue slot.
    assign full  = q_full;
    assign empty = !res_valid;

    pptach_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (push && !q_full),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_push     (q_push),
        .o_job      (q_job)
    );

    pptach_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_job),
        .o_full  (q_full),
        .i_pop   (q_take),
        .o_stat  (q_stat)
    );

    // The back end holds one finished result in its output register and
    // starts the next read once that result has been popped.
    pptach_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (q_stat),
        .o_take  (q_take),
        .o_valid (res_valid),
        .o_out   (o_out),
        .i_pop   (pop)
    );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pptach_pkg::*;

    // The run is stopped here if the unit hangs.
    localparam int CYCLE_LIMIT = 400000;

    // Cycles left after the last reading before the registers are touched
    // again. A read that is still in the divider would show up well inside
    // this window.
    localparam int SETTLE_CYCLES = 40;

    // Cycles for which the receiver refuses every result, so that reads
    // pile up in the unit and it stops taking input.
    localparam int HOLD_OFF_CYCLES = 600;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    t_in         i_in = '0;
    logic        empty;
    logic        pop = 1'b0;
    t_out        o_out;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_WRAP;
    logic [31:0] i_cfg_data = '0;

    always #4 i_clk = ~i_clk;

    pwm_period_capture_tachometer_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in       (i_in),
        .empty      (empty),
        .pop        (pop),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Items waiting to be offered, readings still owed by the unit, and the
    // counters that tell the stimulus process when the unit has gone quiet.
    t_in  tach_items[$];
    t_out readings_due[$];
    int   items_queued = 0;
    int   items_taken = 0;
    int   results_seen = 0;
    int   mismatches = 0;
    int   cycle_count = 0;

    // Our own copy of the tachometer: registers first, then the state.
    logic [15:0]      wrap_cfg;
    logic [31:0]      timeout_cfg;
    logic             last_level;
    logic [1:0]       phase;
    logic [CNT_W-1:0] tick_count;
    logic [31:0]      wrap_sum;
    logic [15:0]      high_time;
    logic [31:0]      period_time;
    logic [31:0]      pin_events;

    function automatic logic [31:0] sum_sat32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] total;
        total = {1'b0, a} + {1'b0, b};
        return total[32] ? 32'hFFFF_FFFF : total[31:0];
    endfunction

    function automatic void tach_reset();
        wrap_cfg    = WRAP_RESET;
        timeout_cfg = TIMEOUT_RESET;
        last_level  = 1'b1;
        phase       = PH_IDLE;
        tick_count  = '0;
        wrap_sum    = '0;
        high_time   = '0;
        period_time = '0;
        pin_events  = '0;
    endfunction

    // Applies one accepted item to the copy of the unit. Returns 1 when the
    // item is a read, with the reading the unit must give back in res.
    function automatic bit tach_step(input t_in item, output t_out res);
        logic [16:0] span;
        logic [32:0] bumped;
        logic        rise;
        logic        fall;
        logic [31:0] quotient;
        res = '0;
        case (item.op)
            OP_TICK: begin
                // A wrap period of zero counts like a period of one.
                span   = (wrap_cfg == 16'd0) ? 17'd1 : {1'b0, wrap_cfg};
                bumped = 33'(tick_count) + 33'd1;
                if (bumped >= 33'(span) || tick_count == '1) begin
                    tick_count = '0;
                    wrap_sum   = sum_sat32(wrap_sum, 32'(wrap_cfg));
                end else begin
                    tick_count = tick_count + 1'b1;
                end
                return 1'b0;
            end
            OP_PIN: begin
                rise = !last_level && item.pin_level;
                fall = last_level && !item.pin_level;
                case (phase)
                    PH_IDLE: begin
                        if (rise) begin
                            phase      = PH_ROSE;
                            tick_count = '0;
                            wrap_sum   = '0;
                        end
                    end
                    PH_ROSE: begin
                        if (fall) begin
                            phase     = PH_FELL;
                            high_time = 16'(tick_count);
                        end else begin
                            phase = PH_IDLE;
                        end
                    end
                    PH_FELL: begin
                        if (rise) begin
                            phase       = PH_ROSE;
                            period_time = sum_sat32(32'(tick_count), wrap_sum);
                            tick_count  = '0;
                            wrap_sum    = '0;
                        end else begin
                            phase = PH_IDLE;
                        end
                    end
                    default: phase = PH_IDLE;
                endcase
                last_level = item.pin_level;
                pin_events = pin_events + 32'd1;
                return 1'b0;
            end
            OP_READ: begin
                res.stalled      = (wrap_sum > timeout_cfg);
                res.period_ticks = period_time;
                res.high_ticks   = high_time;
                res.pulse_total  = pin_events;
                if (period_time == 32'd0 || res.stalled) begin
                    res.rpm = '0;
                end else begin
                    quotient = (32'd60 * 32'(wrap_cfg)) / period_time;
                    res.rpm  = (quotient > 32'(RPM_MAX)) ? RPM_MAX : quotient[15:0];
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Driver. The sender offers items in bursts of random length separated
    // by random gaps; some gaps are zero, so long stretches go back to back.
    // An item stays on the port until the unit takes it, and it is applied
    // to our copy of the unit at the very edge at which it is accepted.
    int   burst_left = 0;
    int   gap_left = 0;
    t_out next_reading;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            burst_left = 0;
            gap_left = 0;
            tach_reset();
        end else begin
            if (push && !full) begin
                if (tach_step(i_in, next_reading))
                    readings_due.push_back(next_reading);
                items_taken++;
            end
            if (!push || !full) begin
                if (gap_left > 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (tach_items.size() != 0) begin
                    i_in <= tach_items.pop_front();
                    push <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Monitor. Every result beat taken is compared with the oldest reading
    // still owed. The receiver switches its stall pattern at random:
    // always ready, ready half the time, or ready only now and then.
    // Twice in the run it also refuses results for a long stretch, so that
    // the unit fills with reads and pushes back on the sender.
    int   hold_left = 0;
    int   rx_mode = 0;
    int   rx_left = 32;
    t_out want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (readings_due.size() == 0) begin
                    $error("result beat with no read waiting: rpm %0d, period %0d",
                           o_out.rpm, o_out.period_ticks);
                    mismatches++;
                end else begin
                    want = readings_due.pop_front();
                    check_field("rpm", 32'(want.rpm), 32'(o_out.rpm));
                    check_field("period_ticks", want.period_ticks, o_out.period_ticks);
                    check_field("high_ticks", 32'(want.high_ticks), 32'(o_out.high_ticks));
                    check_field("pulse_total", want.pulse_total, o_out.pulse_total);
                    check_field("stalled", 32'(want.stalled), 32'(o_out.stalled));
                end
                results_seen++;
                if (results_seen == 30 || results_seen == 60)
                    hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                case (rx_mode)
                    0:       pop <= 1'b1;
                    1:       pop <= ($urandom_range(0, 1) == 1);
                    default: pop <= ($urandom_range(0, 7) == 0);
                endcase
                if (rx_left > 0) begin
                    rx_left--;
                end else begin
                    rx_mode = $urandom_range(0, 2);
                    rx_left = $urandom_range(8, 64);
                end
            end
        end
    end

    // Watchdog: a hung unit ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic put_item(input logic [1:0] op, input logic level);
        t_in item;
        item.op = op;
        item.pin_level = level;
        tach_items.push_back(item);
        items_queued++;
    endtask

    // Ticks carry a random pin level, which the unit must ignore.
    task automatic put_ticks(input int count);
        repeat (count) put_item(OP_TICK, 1'($urandom_range(0, 1)));
    endtask

    task automatic maybe_read();
        if ($urandom_range(0, 3) == 0)
            put_item(OP_READ, 1'($urandom_range(0, 1)));
    endtask

    // Random traffic. Most of it is a clean square wave on the pin with
    // random high and low times, so that the capture machine keeps going
    // through rise, fall and rise and keeps capturing periods. The rest is
    // noise (any op including the unused one, repeated levels that break
    // the sequence) and bursts of reads that fill the result queue.
    task automatic gen_traffic(input int count, input int tick_max);
        int start;
        int pick;
        start = items_queued;
        while (items_queued - start < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                put_item(OP_PIN, 1'b1);
                put_ticks($urandom_range(0, tick_max));
                maybe_read();
                put_item(OP_PIN, 1'b0);
                put_ticks($urandom_range(0, tick_max));
                maybe_read();
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 3))
                    put_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            end else begin
                repeat ($urandom_range(1, 4)) put_item(OP_READ, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic cfg_write(input logic idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_WRAP)
            wrap_cfg = data[15:0];
        else
            timeout_cfg = data;
    endtask

    // Waits until every item has been taken and every reading has come
    // back, then gives the unit time to finish any work still inside it.
    task automatic wait_quiet();
        do @(posedge i_clk);
        while (items_taken != items_queued || readings_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] wrap_plan [6];
        logic [31:0] timeout_plan [6];
        int          tick_plan [6];
        wrap_plan    = '{16'd7, 16'd1, 16'd0, 16'hFFFF, 16'd300, 16'd25};
        timeout_plan = '{32'd20, 32'd0, 32'd3, 32'hFFFF_FFFF, 32'd1000, 32'd60};
        tick_plan    = '{30, 4, 4, 40, 40, 60};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, with the registers at their reset values.
        // A read straight after reset sees nothing captured yet.
        put_item(OP_READ, 1'b0);
        // The unused op does nothing and gives no result.
        put_item(2'd3, 1'b1);
        put_item(2'd3, 1'b0);
        // The pin starts high: a high level and then a fall leave it idle.
        put_item(OP_PIN, 1'b1);
        put_item(OP_PIN, 1'b0);
        // Rise, fall and rise with no tick in between: a zero period,
        // which must read back as zero RPM.
        put_item(OP_PIN, 1'b1);
        put_item(OP_PIN, 1'b0);
        put_item(OP_PIN, 1'b1);
        put_item(OP_READ, 1'b1);
        // A two-tick period: the RPM saturates.
        put_item(OP_TICK, 1'b1);
        put_item(OP_PIN, 1'b0);
        put_item(OP_TICK, 1'b0);
        put_item(OP_PIN, 1'b1);
        put_item(OP_READ, 1'b0);
        // A level repeated while waiting for the fall drops back to idle.
        put_ticks(3);
        put_item(OP_PIN, 1'b1);
        put_item(OP_PIN, 1'b0);
        put_item(OP_READ, 1'b0);
        // A level repeated while waiting for the second rise drops to idle.
        put_item(OP_PIN, 1'b1);
        put_ticks(2);
        put_item(OP_PIN, 1'b0);
        put_item(OP_PIN, 1'b0);
        put_item(OP_READ, 1'b1);
        wait_quiet();

        // Six register settings, extremes included, each with random traffic.
        for (int k = 0; k < 6; k++) begin
            cfg_write(CFG_WRAP, {16'd0, wrap_plan[k]});
            cfg_write(CFG_TIMEOUT, timeout_plan[k]);
            gen_traffic(225, tick_plan[k]);
            wait_quiet();
        end
        cfg_write(CFG_WRAP, 32'($urandom_range(2, 60)));
        cfg_write(CFG_TIMEOUT, 32'($urandom_range(0, 200)));
        gen_traffic(225, 50);
        wait_quiet();

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
